// ===== rtl/triangle_plane_box_setup_assert.svh =====
// Assertion macros shared by the triangle setup RTL.
// Both macros sample on the rising edge of aclk and stay quiet during reset.
`ifndef TRIANGLE_PLANE_BOX_SETUP_ASSERT_SVH
`define TRIANGLE_PLANE_BOX_SETUP_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge.
`define TPBS_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the next clock edge.
`define TPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`else

`define TPBS_ASSERT_NOW(lbl, cond, msg)
`define TPBS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tpbs_pkg.sv =====
package tpbs_pkg;

    // Default coordinate width in bits, 4 fraction bits.
    localparam int COORD_BITS_DEF = 16;

    // Fixed result field widths.
    localparam int NORMAL_W  = 35;
    localparam int OFFSET_W  = 52;
    localparam int LEN_W     = 60;
    localparam int LEN_SHIFT = 8;
    localparam int BOX_W     = 17;
    localparam int SURF_W    = 5;
    localparam int M_TDATA_W = 320;

    // Box padding in units of 1/16.
    localparam int PAD_S_XZ  = 8;
    localparam int PAD_S_YLO = 8;
    localparam int PAD_S_YHI = 48;
    localparam int PAD_L_XZ  = 16;
    localparam int PAD_L_YLO = 80;
    localparam int PAD_L_YHI = 160;

    // Padded bounding box of one triangle.
    typedef struct packed {
        logic [BOX_W-1:0] max_z;
        logic [BOX_W-1:0] max_y;
        logic [BOX_W-1:0] max_x;
        logic [BOX_W-1:0] min_z;
        logic [BOX_W-1:0] min_y;
        logic [BOX_W-1:0] min_x;
    } box_t;

    // Load strobes for the two box stages.
    typedef struct packed {
        logic load_minmax;
        logic load_pad;
    } box_ctrl_t;

endpackage

// ===== rtl/tpbs_box.sv =====
module tpbs_box #(
    parameter int COORD_BITS = tpbs_pkg::COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  tpbs_pkg::box_ctrl_t        ctrl,
    input  logic                       pad_small,
    input  logic signed [COORD_BITS:0] vtx [3][3],
    output tpbs_pkg::box_t             box
);

    localparam int NW  = COORD_BITS + 1;
    localparam int BXW = (COORD_BITS + 2 > tpbs_pkg::BOX_W) ? COORD_BITS + 2 : tpbs_pkg::BOX_W;

    logic signed [NW-1:0]  lo_reg [3];
    logic signed [NW-1:0]  hi_reg [3];
    logic signed [NW-1:0]  lo_next [3];
    logic signed [NW-1:0]  hi_next [3];
    logic signed [BXW-1:0] lo_pad [3];
    logic signed [BXW-1:0] hi_pad [3];
    logic signed [BXW-1:0] pad_lo [3];
    logic signed [BXW-1:0] pad_hi [3];
    tpbs_pkg::box_t        box_reg;
    tpbs_pkg::box_t        box_next;

    // Minimum and maximum of the three vertices on each axis.
    always_comb begin
        logic signed [NW-1:0] lo01;
        logic signed [NW-1:0] hi01;
        lo01 = '0;
        hi01 = '0;
        for (int k = 0; k < 3; k++) begin
            lo01 = (vtx[0][k] < vtx[1][k]) ? vtx[0][k] : vtx[1][k];
            hi01 = (vtx[0][k] > vtx[1][k]) ? vtx[0][k] : vtx[1][k];
            lo_next[k] = (vtx[2][k] < lo01) ? vtx[2][k] : lo01;
            hi_next[k] = (vtx[2][k] > hi01) ? vtx[2][k] : hi01;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_minmax) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Padding depends on the mode; Y has its own amounts below and above.
    always_comb begin
        if (pad_small) begin
            pad_lo[0] = BXW'(tpbs_pkg::PAD_S_XZ);
            pad_hi[0] = BXW'(tpbs_pkg::PAD_S_XZ);
            pad_lo[1] = BXW'(tpbs_pkg::PAD_S_YLO);
            pad_hi[1] = BXW'(tpbs_pkg::PAD_S_YHI);
            pad_lo[2] = BXW'(tpbs_pkg::PAD_S_XZ);
            pad_hi[2] = BXW'(tpbs_pkg::PAD_S_XZ);
        end else begin
            pad_lo[0] = BXW'(tpbs_pkg::PAD_L_XZ);
            pad_hi[0] = BXW'(tpbs_pkg::PAD_L_XZ);
            pad_lo[1] = BXW'(tpbs_pkg::PAD_L_YLO);
            pad_hi[1] = BXW'(tpbs_pkg::PAD_L_YHI);
            pad_lo[2] = BXW'(tpbs_pkg::PAD_L_XZ);
            pad_hi[2] = BXW'(tpbs_pkg::PAD_L_XZ);
        end
        for (int k = 0; k < 3; k++) begin
            lo_pad[k] = BXW'(lo_reg[k]) - pad_lo[k];
            hi_pad[k] = BXW'(hi_reg[k]) + pad_hi[k];
        end
        box_next.min_x = lo_pad[0][tpbs_pkg::BOX_W-1:0];
        box_next.min_y = lo_pad[1][tpbs_pkg::BOX_W-1:0];
        box_next.min_z = lo_pad[2][tpbs_pkg::BOX_W-1:0];
        box_next.max_x = hi_pad[0][tpbs_pkg::BOX_W-1:0];
        box_next.max_y = hi_pad[1][tpbs_pkg::BOX_W-1:0];
        box_next.max_z = hi_pad[2][tpbs_pkg::BOX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_pad) begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

// ===== rtl/triangle_plane_box_setup.sv =====
// Triangle plane and bounding-box setup.
// The s_ channel takes one triangle per item: nine signed coordinates with
// 4 fraction bits in s_tdata and a surface code in s_tuser. The m_ channel
// returns one item per triangle: the plane normal, the plane offset, the
// squared normal length and the padded bounding box in m_tdata, and the
// surface code again in m_tuser. X is negated before any use.
// The cfg_ channel writes the padding mode (1 = small, 0 = large); it is
// always ready; the user must write it only while no item is in flight (not enforced).
// The datapath is a seven-stage pipeline. The accepting edge loads the first
// stage, and a result is offered from the registers of the seventh stage;
// one item enters every cycle unless a full pipeline is stalled. The depth is
// set by the cross product, the split squaring of the normal and the two
// summing adders that follow. Every stage has its own valid bit and takes a
// new item whenever it is empty or its successor moves, so bubbles close up
// and up to seven items wait inside while the receiver stalls. Nothing is
// lost or repeated under a stall.
// Reset clears the valid bits and selects large padding; no clearing pass
// is needed and items are accepted in the first cycle after reset.
`include "triangle_plane_box_setup_assert.svh"

module triangle_plane_box_setup #(
    parameter int COORD_BITS = tpbs_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_W = ((9 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: ax, ay, az, bx, by, bz, cx, cy, cz, zero fill.
    input  logic [S_TDATA_W-1:0]           s_tdata,
    // s_tuser: surface_type.
    input  logic [tpbs_pkg::SURF_W-1:0]    s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: normal_x, normal_y, normal_z, plane_offset, normal_len_sq,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // zero fill.
    output logic [tpbs_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: surface_type_out.
    output logic [tpbs_pkg::SURF_W-1:0]    m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);

    localparam int NW    = COORD_BITS + 1;
    localparam int EW    = COORD_BITS + 2;
    localparam int PW    = 2 * EW;
    localparam int NRMW  = PW + 1;
    localparam int LOW_W = (NRMW + 1) / 2;
    localparam int HI_W  = NRMW - LOW_W;
    localparam int HHW   = 2 * HI_W;
    localparam int HLW   = HI_W + LOW_W + 1;
    localparam int LLW   = 2 * LOW_W;
    localparam int SQW   = 2 * NRMW;
    localparam int LREQ  = tpbs_pkg::LEN_SHIFT + tpbs_pkg::LEN_W;
    localparam int LSW   = (SQW + 2 > LREQ) ? SQW + 2 : LREQ;
    localparam int DPW   = NRMW + NW;
    localparam int DSW   = DPW + 2;
    localparam int DOTW  = (DSW > tpbs_pkg::OFFSET_W) ? DSW : tpbs_pkg::OFFSET_W;
    localparam int NOW   = (NRMW > tpbs_pkg::NORMAL_W) ? NRMW : tpbs_pkg::NORMAL_W;
    localparam int FILL_W = tpbs_pkg::M_TDATA_W - 3 * tpbs_pkg::NORMAL_W
                          - tpbs_pkg::OFFSET_W - tpbs_pkg::LEN_W - 6 * tpbs_pkg::BOX_W;

    // Pipeline control.
    logic [7:1] v_reg;
    logic [7:1] v_next;
    logic [8:1] en;
    logic       pad_small_reg;

    // Stage payloads.
    logic signed [NW-1:0]      vtx1_reg [3][3];
    logic signed [NW-1:0]      a2_reg [3];
    logic signed [NW-1:0]      a3_reg [3];
    logic signed [NW-1:0]      a4_reg [3];
    logic signed [EW-1:0]      ab_reg [3];
    logic signed [EW-1:0]      bc_reg [3];
    logic signed [PW-1:0]      prod_reg [6];
    logic signed [NRMW-1:0]    n4_reg [3];
    logic signed [NRMW-1:0]    n5_reg [3];
    logic signed [NRMW-1:0]    n6_reg [3];
    logic signed [NRMW-1:0]    n7_reg [3];
    logic signed [HHW-1:0]     hh_reg [3];
    logic signed [HLW-1:0]     hl_reg [3];
    logic [LLW-1:0]            ll_reg [3];
    logic signed [DPW-1:0]     dp_reg [3];
    logic signed [SQW-1:0]     sq_reg [3];
    logic signed [DOTW-1:0]    dot6_reg;
    logic signed [DOTW-1:0]    dot7_reg;
    logic [LSW-1:0]            len7_reg;
    logic [tpbs_pkg::SURF_W-1:0] surf_reg [1:7];
    tpbs_pkg::box_t            box3;
    tpbs_pkg::box_t            box4_reg;
    tpbs_pkg::box_t            box5_reg;
    tpbs_pkg::box_t            box6_reg;
    tpbs_pkg::box_t            box7_reg;
    tpbs_pkg::box_ctrl_t       box_ctrl;
    logic signed [NOW-1:0]     n_out [3];

    // A stage moves when it is empty or its successor moves.
    always_comb begin
        en[8] = m_tready;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[1] = en[1] ? s_tvalid : v_reg[1];
        for (int k = 2; k <= 7; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[7];

    // Padding mode register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_small_reg <= 1'b0;
        end else if (cfg_valid) begin
            pad_small_reg <= cfg_data;
        end
    end

    // Stage 1: unpack the vertices and negate X.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int v = 0; v < 3; v++) begin
                vtx1_reg[v][0] <= -(NW'($signed(s_tdata[(3*v)*COORD_BITS +: COORD_BITS])));
                vtx1_reg[v][1] <= NW'($signed(s_tdata[(3*v+1)*COORD_BITS +: COORD_BITS]));
                vtx1_reg[v][2] <= NW'($signed(s_tdata[(3*v+2)*COORD_BITS +: COORD_BITS]));
            end
            surf_reg[1] <= s_tuser;
        end
    end

    // Stage 2: edges AB and BC.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < 3; k++) begin
                ab_reg[k] <= EW'(vtx1_reg[1][k]) - EW'(vtx1_reg[0][k]);
                bc_reg[k] <= EW'(vtx1_reg[2][k]) - EW'(vtx1_reg[1][k]);
                a2_reg[k] <= vtx1_reg[0][k];
            end
            surf_reg[2] <= surf_reg[1];
        end
    end

    // Stages 2 and 3 of the bounding box.
    assign box_ctrl.load_minmax = en[2];
    assign box_ctrl.load_pad    = en[3];

    tpbs_box #(
        .COORD_BITS(COORD_BITS)
    ) u_box (
        .aclk      (aclk),
        .ctrl      (box_ctrl),
        .pad_small (pad_small_reg),
        .vtx       (vtx1_reg),
        .box       (box3)
    );

    // Stage 3: the six cross product terms.
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            prod_reg[0] <= PW'(bc_reg[1]) * PW'(ab_reg[2]);
            prod_reg[1] <= PW'(bc_reg[2]) * PW'(ab_reg[1]);
            prod_reg[2] <= PW'(bc_reg[2]) * PW'(ab_reg[0]);
            prod_reg[3] <= PW'(bc_reg[0]) * PW'(ab_reg[2]);
            prod_reg[4] <= PW'(bc_reg[0]) * PW'(ab_reg[1]);
            prod_reg[5] <= PW'(bc_reg[1]) * PW'(ab_reg[0]);
            a3_reg      <= a2_reg;
            surf_reg[3] <= surf_reg[2];
        end
    end

    // Stage 4: normal n = BC x AB.
    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                n4_reg[k] <= NRMW'(prod_reg[2*k]) - NRMW'(prod_reg[2*k+1]);
            end
            a4_reg      <= a3_reg;
            box4_reg    <= box3;
            surf_reg[4] <= surf_reg[3];
        end
    end

    // Stage 5: n dot A terms, and each component squared in three pieces
    // (signed high half, unsigned low half).
    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                dp_reg[k] <= DPW'(n4_reg[k]) * DPW'(a4_reg[k]);
                hh_reg[k] <= HHW'($signed(n4_reg[k][NRMW-1:LOW_W]))
                           * HHW'($signed(n4_reg[k][NRMW-1:LOW_W]));
                hl_reg[k] <= HLW'($signed(n4_reg[k][NRMW-1:LOW_W]))
                           * HLW'($signed({1'b0, n4_reg[k][LOW_W-1:0]}));
                ll_reg[k] <= LLW'(n4_reg[k][LOW_W-1:0]) * LLW'(n4_reg[k][LOW_W-1:0]);
            end
            n5_reg      <= n4_reg;
            box5_reg    <= box4_reg;
            surf_reg[5] <= surf_reg[4];
        end
    end

    // Stage 6: negated dot product and the per-component squares.
    always_ff @(posedge aclk) begin
        if (en[6]) begin
            dot6_reg <= -(DOTW'(dp_reg[0]) + DOTW'(dp_reg[1]) + DOTW'(dp_reg[2]));
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= (SQW'(hh_reg[k]) <<< (2 * LOW_W))
                           + (SQW'(hl_reg[k]) <<< (LOW_W + 1))
                           + $signed(SQW'(ll_reg[k]));
            end
            n6_reg      <= n5_reg;
            box6_reg    <= box5_reg;
            surf_reg[6] <= surf_reg[5];
        end
    end

    // Stage 7: squared length, held in the output register.
    always_ff @(posedge aclk) begin
        if (en[7]) begin
            len7_reg    <= LSW'(sq_reg[0]) + LSW'(sq_reg[1]) + LSW'(sq_reg[2]);
            dot7_reg    <= dot6_reg;
            n7_reg      <= n6_reg;
            box7_reg    <= box6_reg;
            surf_reg[7] <= surf_reg[6];
        end
    end

    // Result packing.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_out[k] = NOW'(n7_reg[k]);
        end
    end

    assign m_tdata = {
        {FILL_W{1'b0}},
        box7_reg.max_z,
        box7_reg.max_y,
        box7_reg.max_x,
        box7_reg.min_z,
        box7_reg.min_y,
        box7_reg.min_x,
        len7_reg[tpbs_pkg::LEN_SHIFT +: tpbs_pkg::LEN_W],
        dot7_reg[tpbs_pkg::OFFSET_W-1:0],
        n_out[2][tpbs_pkg::NORMAL_W-1:0],
        n_out[1][tpbs_pkg::NORMAL_W-1:0],
        n_out[0][tpbs_pkg::NORMAL_W-1:0]
    };
    assign m_tuser = surf_reg[7];

    // An accepted item is held by the first stage.
    `TPBS_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, v_reg[1], "accepted item lost at stage 1")

    // A stalled stage keeps its item.
    `TPBS_ASSERT_NEXT(a_stall_keeps, v_reg[6] && !en[7], v_reg[6], "item dropped under stall")

    // A square assembled from its pieces is never negative.
    `TPBS_ASSERT_NOW(a_square_sign,
        !v_reg[6] || (!sq_reg[0][SQW-1] && !sq_reg[1][SQW-1] && !sq_reg[2][SQW-1]),
        "negative square of a normal component")

endmodule
